// ----- hdl/mhpq_pkg.sv -----
package mhpq_pkg;

  localparam int KEY_W       = 32;
  localparam int OUT_CNT_W   = 7;
  localparam int DEF_CAPACITY = 64;

  typedef enum logic {
    FUNC_INSERT = 1'b0,
    FUNC_DELETE = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    func_t                    func;
    logic signed [KEY_W-1:0]  key_value;
  } in_word_t;

  typedef struct packed {
    status_t                  status;
    logic signed [KEY_W-1:0]  removed_value;
    logic signed [KEY_W-1:0]  min_value;
    logic [OUT_CNT_W-1:0]     entry_count;
    logic                     is_empty;
  } out_word_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_INS_CHK,
    S_INS_CMP,
    S_DEL_LD,
    S_DN_RD,
    S_DN_CMP,
    S_ROOT_RD,
    S_OUT
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_REJ_FULL,
    OP_REJ_EMPTY,
    OP_INS_BEGIN,
    OP_INS_RD,
    OP_INS_MOVE,
    OP_INS_PUT,
    OP_DEL_RD,
    OP_DEL_LD,
    OP_DN_RD,
    OP_DN_MOVE,
    OP_DN_PUT,
    OP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } ctl_cmd_t;

  typedef struct packed {
    logic func_del;
    logic full;
    logic empty;
    logic pos_zero;
    logic up_go;
    logic dn_go;
    logic out_free;
  } dp_stat_t;

endpackage

// ----- hdl/min_heap_priority_queue.sv -----
// Binary min-heap priority queue, up to CAPACITY signed 32-bit keys.
//
// Input channel (in_valid / in_stall / in_word): each word is an insert of
// key_value (func = insert) or a delete-minimum (func = delete). The word is
// taken on a clock edge with in_valid high and in_stall low. One word is
// worked at a time; in_stall is high from acceptance until its result loads.
//
// Result channel (out_valid / out_stall / out_word): exactly one word per
// input word: status, removed minimum, new root (-1 when empty), entry count
// and empty flag. The result sits in an output register, so a stalled result
// does not block the next input word; only the following result waits.
//
// An insert climbs its key level by level toward the root; a delete moves
// the last entry to the root and sinks it level by level, skipping the sink
// when the last entry leaves; a rejected word goes straight to the result. A
// level is a registered RAM read plus a compare-and-write step. The next word
// can be taken in the cycle after out_valid rises.
//
// Reset (rst_n low, synchronous) empties the heap and drops any pending
// result; the RAM contents are not cleared.
module min_heap_priority_queue #(
  parameter int CAPACITY = mhpq_pkg::DEF_CAPACITY
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  mhpq_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output mhpq_pkg::out_word_t out_word
);

  import mhpq_pkg::*;

  // controller <-> datapath
  ctl_cmd_t cmd;
  dp_stat_t stat;

  // sequencer: walks sift-up / sift-down one level at a time
  mhpq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // heap RAM, count, hole position and result register
  mhpq_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

// ----- hdl/mhpq_ram.sv -----
module mhpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_a_r;
  logic [WIDTH-1:0] rd_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_a_r <= mem[raddr_a];
    rd_b_r <= mem[raddr_b];
  end

  assign rdata_a = rd_a_r;
  assign rdata_b = rd_b_r;

endmodule

// ----- hdl/mhpq_dp.sv -----
module mhpq_dp #(
  parameter int CAPACITY = mhpq_pkg::DEF_CAPACITY
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mhpq_pkg::ctl_cmd_t  cmd,
  output mhpq_pkg::dp_stat_t  stat,
  input  mhpq_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output mhpq_pkg::out_word_t out_word
);

  import mhpq_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = AW + 2;
  localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

  func_t            func_r,    func_nxt;
  logic [KEY_W-1:0] key_r,     key_nxt;
  logic [KEY_W-1:0] removed_r, removed_nxt;
  status_t          status_r,  status_nxt;
  logic [CW-1:0]    count_r,   count_nxt;
  logic [AW-1:0]    pos_r,     pos_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_word_t        out_word_r,  out_word_nxt;

  logic             we;
  logic [AW-1:0]    waddr;
  logic [KEY_W-1:0] wdata;
  logic [AW-1:0]    raddr_a;
  logic [AW-1:0]    raddr_b;
  logic [KEY_W-1:0] rd_a;
  logic [KEY_W-1:0] rd_b;

  logic [IW-1:0]    li;
  logic [IW-1:0]    ri;
  logic [IW-1:0]    cnt_i;
  logic [AW-1:0]    parent;
  logic [KEY_W-1:0] best_val;
  logic             l_win;
  logic             r_win;
  logic             up_go;
  logic             out_free;

  mhpq_ram #(
    .WIDTH (KEY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  // child / parent indexes and compares
  assign li       = IW'({pos_r, 1'b0}) + IW'(1);
  assign ri       = li + IW'(1);
  assign cnt_i    = IW'(count_r);
  assign parent   = (pos_r - AW'(1)) >> 1;
  assign l_win    = (li < cnt_i) && ($signed(rd_a) < $signed(key_r));
  assign best_val = l_win ? rd_a : key_r;
  assign r_win    = (ri < cnt_i) && ($signed(rd_b) < $signed(best_val));
  assign up_go    = $signed(key_r) < $signed(rd_a);
  assign out_free = !out_valid_r || !out_stall;

  assign stat.func_del = (func_r == FUNC_DELETE);
  assign stat.full     = (count_r == CAP_CNT);
  assign stat.empty    = (count_r == '0);
  assign stat.pos_zero = (pos_r == '0);
  assign stat.up_go    = up_go;
  assign stat.dn_go    = l_win || r_win;
  assign stat.out_free = out_free;

  always_comb begin
    func_nxt      = func_r;
    key_nxt       = key_r;
    removed_nxt   = removed_r;
    status_nxt    = status_r;
    count_nxt     = count_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_word_nxt  = out_word_r;
    we            = 1'b0;
    waddr         = pos_r;
    wdata         = key_r;
    raddr_a       = '0;
    raddr_b       = '0;
    case (cmd.op)
      OP_LOAD: begin
        func_nxt    = in_word.func;
        key_nxt     = in_word.key_value;
        removed_nxt = '0;
        status_nxt  = STAT_OK;
      end
      OP_REJ_FULL: begin
        status_nxt = STAT_FULL;
      end
      OP_REJ_EMPTY: begin
        status_nxt = STAT_EMPTY;
      end
      OP_INS_BEGIN: begin
        pos_nxt   = AW'(count_r);
        count_nxt = count_r + CW'(1);
      end
      OP_INS_RD: begin
        raddr_a = parent;
      end
      OP_INS_MOVE: begin
        we      = 1'b1;
        wdata   = rd_a;
        pos_nxt = parent;
      end
      OP_INS_PUT, OP_DN_PUT: begin
        we = 1'b1;
      end
      OP_DEL_RD: begin
        raddr_b   = AW'(count_r - CW'(1));
        count_nxt = count_r - CW'(1);
      end
      OP_DEL_LD: begin
        removed_nxt = rd_a;
        key_nxt     = rd_b;
        pos_nxt     = '0;
      end
      OP_DN_RD: begin
        raddr_a = li[AW-1:0];
        raddr_b = ri[AW-1:0];
      end
      OP_DN_MOVE: begin
        we      = 1'b1;
        wdata   = r_win ? rd_b : rd_a;
        pos_nxt = r_win ? ri[AW-1:0] : li[AW-1:0];
      end
      OP_OUT: begin
        out_valid_nxt              = 1'b1;
        out_word_nxt.status        = status_r;
        out_word_nxt.removed_value = removed_r;
        out_word_nxt.min_value     = (count_r == '0) ? '1 : rd_a;
        out_word_nxt.entry_count   = OUT_CNT_W'(count_r);
        out_word_nxt.is_empty      = (count_r == '0);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    func_r     <= func_nxt;
    key_r      <= key_nxt;
    removed_r  <= removed_nxt;
    status_r   <= status_nxt;
    pos_r      <= pos_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_CNT)
    else $error("entry count above capacity");

  a_write_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> (CW'(pos_r) < count_r))
    else $error("heap write outside filled region");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op != OP_INS_BEGIN && cmd.op != OP_DEL_RD) |=> $stable(count_r))
    else $error("entry count changed outside insert/delete start");

endmodule

// ----- hdl/mhpq_ctrl.sv -----
module mhpq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  mhpq_pkg::dp_stat_t stat,
  output mhpq_pkg::ctl_cmd_t cmd
);

  import mhpq_pkg::*;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DISPATCH;
      end
      S_DISPATCH: begin
        if (stat.func_del) begin
          state_nxt = stat.empty ? S_ROOT_RD : S_DEL_LD;
        end else begin
          state_nxt = stat.full ? S_ROOT_RD : S_INS_CHK;
        end
      end
      S_INS_CHK: state_nxt = stat.pos_zero ? S_ROOT_RD : S_INS_CMP;
      S_INS_CMP: state_nxt = stat.up_go ? S_INS_CHK : S_ROOT_RD;
      S_DEL_LD:  state_nxt = stat.empty ? S_ROOT_RD : S_DN_RD;
      S_DN_RD:   state_nxt = S_DN_CMP;
      S_DN_CMP:  state_nxt = stat.dn_go ? S_DN_RD : S_ROOT_RD;
      S_ROOT_RD: state_nxt = S_OUT;
      S_OUT: begin
        if (stat.out_free) state_nxt = S_IDLE;
      end
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.op   = OP_NONE;
    in_stall = (state_r != S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_valid) cmd.op = OP_LOAD;
      end
      S_DISPATCH: begin
        if (stat.func_del) begin
          cmd.op = stat.empty ? OP_REJ_EMPTY : OP_DEL_RD;
        end else begin
          cmd.op = stat.full ? OP_REJ_FULL : OP_INS_BEGIN;
        end
      end
      S_INS_CHK: cmd.op = stat.pos_zero ? OP_INS_PUT : OP_INS_RD;
      S_INS_CMP: cmd.op = stat.up_go ? OP_INS_MOVE : OP_INS_PUT;
      S_DEL_LD:  cmd.op = OP_DEL_LD;
      S_DN_RD:   cmd.op = OP_DN_RD;
      S_DN_CMP:  cmd.op = stat.dn_go ? OP_DN_MOVE : OP_DN_PUT;
      S_OUT: begin
        if (stat.out_free) cmd.op = OP_OUT;
      end
      default:   cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_out_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_OUT) |=> (state_r == S_IDLE))
    else $error("result load did not return to idle");

  a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_DISPATCH))
    else $error("accepted word not dispatched");

endmodule
